/* sv/esd_pkg.sv */
// shared types, character codes and helper functions for the escape sequence decoder
// no dependencies; used by esd_decode, esd_out_fifo and escape_sequence_decoder
package esd_pkg;

  localparam int OUT_DEPTH = 4;
  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_X   = 8'h78;

  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_BEL = 8'd7;

  typedef struct packed {
    logic       eos;
    logic       err;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic  v0;
    item_t i0;
    logic  v1;
    item_t i1;
  } res_t;

  // append one result in the first free slot
  function automatic res_t push(res_t r, logic [7:0] data, logic err);
    res_t o;
    item_t it;
    o = r;
    it.eos = 1'b0;
    it.err = err;
    it.data = err ? 8'd0 : data;
    if (!r.v0) begin
      o.v0 = 1'b1;
      o.i0 = it;
    end else begin
      o.v1 = 1'b1;
      o.i1 = it;
    end
    return o;
  endfunction

  function automatic logic is_octal(logic [7:0] c);
    return c[7:3] == 5'b00110;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* sv/escape_sequence_decoder.sv */
// C escape sequence decoder, top level: input register, decoder and result queue
// depends on esd_pkg, esd_decode, esd_out_fifo
//
// usage
//   slave channel s_*: one character per word, s_tlast on the final
//   character of a string. master channel m_*: decoded bytes, m_tuser set
//   on the single error word of a string with a bad escape, m_tlast on the
//   last word of each string.
//   a character is registered on acceptance and, once the queue has room,
//   decoded into a four-word result queue whose head drives the master side.
//   throughput is one character per cycle while the queue has room. a
//   character that closes a short numeric escape can give two words; the
//   master side drains one word per cycle while m_tready is high, so each
//   such extra word stalls s_tready once the queue fills.
//   reset clears the decoder to outside any escape and empties the queue.
//   when m_tready is low the queue holds its words and s_tready drops once
//   fewer than two slots are free and a character is held in the input register.
module escape_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] is_error
  output logic       m_tlast
);

  logic          in_valid;
  logic [7:0]    in_byte;
  logic          in_last;
  logic          room;
  logic          fire;
  esd_pkg::res_t res;
  esd_pkg::item_t head;

  assign fire = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  esd_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (in_byte),
    .last    (in_last),
    .res     (res)
  );

  esd_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push0 (fire && res.v0),
    .push1 (fire && res.v1),
    .item0 (res.i0),
    .item1 (res.i1),
    .pop   (m_tvalid && m_tready),
    .room  (room),
    .valid (m_tvalid),
    .head  (head)
  );

  assign m_tdata = head.data;
  assign m_tuser = head.err;
  assign m_tlast = head.eos;

  a_pair_ordered: assert property (@(posedge clk) disable iff (rst)
    (fire && res.v1) |-> res.v0)
    else $error("second result without first");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == 8'd0 && m_tlast))
    else $error("error word carries data or is not last");

endmodule

/* sv/esd_decode.sv */
// escape decoding state machine: mode and digit accumulator, up to two results per byte
// depends on esd_pkg
module esd_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      in_byte,
  input  logic            last,
  output esd_pkg::res_t   res
);

  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_ESC  = 7'b0000010,
    MODE_OCT1 = 7'b0000100,
    MODE_OCT2 = 7'b0001000,
    MODE_HEX0 = 7'b0010000,
    MODE_HEX1 = 7'b0100000,
    MODE_ERR  = 7'b1000000
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] acc, acc_next;
  logic [4:0] hx;
  logic       oct;
  esd_pkg::res_t r;

  always_comb begin
    mode_next = mode;
    acc_next = acc;
    hx = esd_pkg::hex_value(in_byte);
    oct = esd_pkg::is_octal(in_byte);
    r = '0;
    unique case (mode)
      MODE_ESC: begin
        mode_next = MODE_IDLE;
        unique case (in_byte)
          esd_pkg::CH_LC_N: r = esd_pkg::push(r, esd_pkg::CODE_LF, 1'b0);
          esd_pkg::CH_LC_T: r = esd_pkg::push(r, esd_pkg::CODE_TAB, 1'b0);
          esd_pkg::CH_LC_V: r = esd_pkg::push(r, esd_pkg::CODE_VT, 1'b0);
          esd_pkg::CH_LC_B: r = esd_pkg::push(r, esd_pkg::CODE_BS, 1'b0);
          esd_pkg::CH_LC_R: r = esd_pkg::push(r, esd_pkg::CODE_CR, 1'b0);
          esd_pkg::CH_LC_F: r = esd_pkg::push(r, esd_pkg::CODE_FF, 1'b0);
          esd_pkg::CH_LC_A: r = esd_pkg::push(r, esd_pkg::CODE_BEL, 1'b0);
          esd_pkg::CH_BSLASH, esd_pkg::CH_QMARK,
          esd_pkg::CH_SQUOTE, esd_pkg::CH_DQUOTE: r = esd_pkg::push(r, in_byte, 1'b0);
          esd_pkg::CH_LC_X: begin
            acc_next = 8'd0;
            mode_next = MODE_HEX0;
          end
          default: begin
            if (oct) begin
              acc_next = {5'd0, in_byte[2:0]};
              mode_next = MODE_OCT1;
            end else begin
              mode_next = MODE_ERR;
            end
          end
        endcase
      end
      MODE_OCT1, MODE_OCT2: begin
        if (oct) begin
          acc_next = {acc[4:0], in_byte[2:0]};
          if (mode == MODE_OCT1) begin
            mode_next = MODE_OCT2;
          end else begin
            mode_next = MODE_IDLE;
            r = esd_pkg::push(r, acc_next, 1'b0);
          end
        end else begin
          r = esd_pkg::push(r, acc, 1'b0);
          if (in_byte == esd_pkg::CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            mode_next = MODE_IDLE;
            r = esd_pkg::push(r, in_byte, 1'b0);
          end
        end
      end
      MODE_HEX0: begin
        if (hx[4]) begin
          acc_next = {4'd0, hx[3:0]};
          mode_next = MODE_HEX1;
        end else begin
          mode_next = MODE_ERR;
        end
      end
      MODE_HEX1: begin
        if (hx[4]) begin
          acc_next = {acc[3:0], hx[3:0]};
          mode_next = MODE_IDLE;
          r = esd_pkg::push(r, acc_next, 1'b0);
        end else begin
          r = esd_pkg::push(r, acc, 1'b0);
          if (in_byte == esd_pkg::CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            mode_next = MODE_IDLE;
            r = esd_pkg::push(r, in_byte, 1'b0);
          end
        end
      end
      MODE_ERR: begin
        mode_next = MODE_ERR;
      end
      default: begin
        if (in_byte == esd_pkg::CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          mode_next = MODE_IDLE;
          r = esd_pkg::push(r, in_byte, 1'b0);
        end
      end
    endcase

    if (last) begin
      priority if (mode_next == MODE_OCT1 || mode_next == MODE_OCT2 ||
                   mode_next == MODE_HEX1) begin
        r = esd_pkg::push(r, acc_next, 1'b0);
      end else if (mode_next == MODE_ESC || mode_next == MODE_HEX0 ||
                   mode_next == MODE_ERR) begin
        r = esd_pkg::push(r, 8'd0, 1'b1);
      end
      if (r.v1) begin
        r.i1.eos = 1'b1;
      end else if (r.v0) begin
        r.i0.eos = 1'b1;
      end
      mode_next = MODE_IDLE;
      acc_next = 8'd0;
    end
  end

  assign res = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      acc <= 8'd0;
    end else if (fire) begin
      mode <= mode_next;
      acc <= acc_next;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (fire && last) |=> (mode == MODE_IDLE && acc == 8'd0))
    else $error("decoder not idle after end of string");

  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && r.v0 && r.i0.err) |-> (r.i0.eos && !r.v1))
    else $error("error result not the final result");

endmodule

/* sv/esd_out_fifo.sv */
// small result queue taking up to two words per cycle, draining one per cycle
// depends on esd_pkg
module esd_out_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push0,
  input  logic           push1,
  input  esd_pkg::item_t item0,
  input  esd_pkg::item_t item1,
  input  logic           pop,
  output logic           room,
  output logic           valid,
  output esd_pkg::item_t head
);

  esd_pkg::item_t mem [esd_pkg::OUT_DEPTH];
  logic [esd_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [esd_pkg::CNT_W-1:0] count, count_next;
  logic [esd_pkg::PTR_W-1:0] wr_ptr1;
  logic [esd_pkg::CNT_W-1:0] n_push;

  assign wr_ptr1 = wr_ptr + esd_pkg::PTR_W'(1);
  assign n_push = esd_pkg::CNT_W'(push0) + esd_pkg::CNT_W'(push1);
  assign count_next = count + n_push - esd_pkg::CNT_W'(pop);
  assign valid = count != '0;
  assign room = count <= esd_pkg::CNT_W'(esd_pkg::OUT_DEPTH - 2);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= item0;
    end
    if (push1) begin
      mem[wr_ptr1] <= item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + esd_pkg::PTR_W'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + esd_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push0 |-> room)
    else $error("result queue written without room");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("result queue read while empty");

endmodule

/* bench/escape_sequence_decoder_test.sv */
// testbench for escape_sequence_decoder: directed and random strings against a built-in decoder model
// a scoreboard class predicts the decoded words; tasks drive s_*, an always block drives m_tready
// depends on esd_pkg and escape_sequence_decoder
module escape_sequence_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;
  localparam int PHASE_CHARS = 320;
  localparam int HOLD_CYCLES = 300;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_G  = 8'h67;

  localparam logic [7:0] ESC_LETTERS [11] = '{
    esd_pkg::CH_LC_N, esd_pkg::CH_LC_T, esd_pkg::CH_LC_V, esd_pkg::CH_LC_B,
    esd_pkg::CH_LC_R, esd_pkg::CH_LC_F, esd_pkg::CH_LC_A,
    esd_pkg::CH_BSLASH, esd_pkg::CH_QMARK, esd_pkg::CH_SQUOTE, esd_pkg::CH_DQUOTE
  };

  typedef enum logic [2:0] {
    M_IDLE, M_ESC, M_OCT1, M_OCT2, M_HEX0, M_HEX1, M_ERR
  } dec_mode_t;

  class escape_board_t;
    dec_mode_t mode;
    logic [7:0] acc;
    esd_pkg::item_t expected_words[$];
    int new_words;
    int errors;

    function new();
      mode = M_IDLE;
      acc = 8'd0;
      errors = 0;
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    function void emit(logic [7:0] value, logic err);
      esd_pkg::item_t it;
      it.eos = 1'b0;
      it.err = err;
      it.data = err ? 8'd0 : value;
      expected_words = {expected_words, it};
      new_words++;
    endfunction

    function bit octal_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= esd_pkg::CH_LC_A && c <= esd_pkg::CH_LC_F) return int'(c - esd_pkg::CH_LC_A) + 10;
      if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
      return -1;
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == esd_pkg::CH_BSLASH) begin
        mode = M_ESC;
      end else begin
        mode = M_IDLE;
        emit(c, 1'b0);
      end
    endfunction

    function void after_bslash(logic [7:0] c);
      mode = M_IDLE;
      case (c)
        esd_pkg::CH_LC_N: emit(esd_pkg::CODE_LF, 1'b0);
        esd_pkg::CH_LC_T: emit(esd_pkg::CODE_TAB, 1'b0);
        esd_pkg::CH_LC_V: emit(esd_pkg::CODE_VT, 1'b0);
        esd_pkg::CH_LC_B: emit(esd_pkg::CODE_BS, 1'b0);
        esd_pkg::CH_LC_R: emit(esd_pkg::CODE_CR, 1'b0);
        esd_pkg::CH_LC_F: emit(esd_pkg::CODE_FF, 1'b0);
        esd_pkg::CH_LC_A: emit(esd_pkg::CODE_BEL, 1'b0);
        esd_pkg::CH_BSLASH, esd_pkg::CH_QMARK,
        esd_pkg::CH_SQUOTE, esd_pkg::CH_DQUOTE: emit(c, 1'b0);
        esd_pkg::CH_LC_X: begin
          acc = 8'd0;
          mode = M_HEX0;
        end
        default: begin
          if (octal_digit(c)) begin
            acc = {5'd0, c[2:0]};
            mode = M_OCT1;
          end else begin
            mode = M_ERR;
          end
        end
      endcase
    endfunction

    // predicts the words caused by one accepted character
    function void note_char(logic [7:0] c, logic last);
      int h;
      new_words = 0;
      case (mode)
        M_ESC: after_bslash(c);
        M_OCT1, M_OCT2: begin
          if (octal_digit(c)) begin
            acc = {acc[4:0], c[2:0]};
            if (mode == M_OCT1) begin
              mode = M_OCT2;
            end else begin
              mode = M_IDLE;
              emit(acc, 1'b0);
            end
          end else begin
            emit(acc, 1'b0);
            plain_char(c);
          end
        end
        M_HEX0: begin
          h = hex_digit(c);
          if (h >= 0) begin
            acc = 8'(h);
            mode = M_HEX1;
          end else begin
            mode = M_ERR;
          end
        end
        M_HEX1: begin
          h = hex_digit(c);
          if (h >= 0) begin
            acc = {acc[3:0], 4'(h)};
            mode = M_IDLE;
            emit(acc, 1'b0);
          end else begin
            emit(acc, 1'b0);
            plain_char(c);
          end
        end
        M_ERR: ;
        default: plain_char(c);
      endcase
      if (last) begin
        case (mode)
          M_OCT1, M_OCT2, M_HEX1: emit(acc, 1'b0);
          M_ESC, M_HEX0, M_ERR: emit(8'd0, 1'b1);
          default: ;
        endcase
        if (new_words > 0) expected_words[$].eos = 1'b1;
        mode = M_IDLE;
        acc = 8'd0;
      end
    endfunction

    task check_word(logic [7:0] data, logic err, logic eos);
      esd_pkg::item_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word data=%h err=%b last=%b", data, err, eos));
      end else begin
        want = expected_words.pop_front();
        if (data !== want.data) report($sformatf("data %h, want %h", data, want.data));
        if (err !== want.err) report($sformatf("error flag %b, want %b", err, want.err));
        if (eos !== want.eos) report($sformatf("last flag %b, want %b", eos, want.eos));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  int  stall_pct = 0;
  int  send_idle = 0;
  logic hold_rx = 1'b0;
  int  cycles = 0;
  int  sent = 0;
  logic [7:0] chars[$];
  escape_board_t board;

  escape_sequence_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function void append_char(logic [7:0] c);
    chars = {chars, c};
  endfunction

  task send_char(logic [7:0] c, logic last);
    logic ok;
    ok = 1'b0;
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    while (!ok) begin
      @(negedge clk);
      ok = s_tready;
      if (ok) board.note_char(c, last);
      @(posedge clk);
    end
    sent++;
  endtask

  task send_string();
    for (int i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
  endtask

  task send_text(string s);
    chars.delete();
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
    send_string();
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? esd_pkg::CH_LC_A : CH_UC_A) + 8'(d - 10);
  endfunction

  task make_string();
    int ntok;
    int kind;
    logic [7:0] c;
    chars.delete();
    // noise: raw bytes with plenty of backslashes
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) begin
        c = ($urandom_range(0, 4) == 0) ? esd_pkg::CH_BSLASH : 8'($urandom_range(1, 255));
        append_char(c);
      end
      return;
    end
    ntok = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
    repeat (ntok) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        c = 8'($urandom_range(1, 255));
        append_char(c);
        if (c == esd_pkg::CH_BSLASH) append_char(esd_pkg::CH_BSLASH);
      end else if (kind < 60) begin
        append_char(esd_pkg::CH_BSLASH);
        append_char(ESC_LETTERS[$urandom_range(0, 10)]);
      end else if (kind < 75) begin
        append_char(esd_pkg::CH_BSLASH);
        repeat ($urandom_range(1, 3)) append_char(CH_ZERO + 8'($urandom_range(0, 7)));
      end else if (kind < 90) begin
        append_char(esd_pkg::CH_BSLASH);
        append_char(esd_pkg::CH_LC_X);
        repeat ($urandom_range(1, 2)) append_char(hex_char());
      end else begin
        append_char(esd_pkg::CH_BSLASH);
        case ($urandom_range(0, 2))
          0: append_char(8'($urandom_range(1, 255)));
          1: begin
            append_char(esd_pkg::CH_LC_X);
            append_char(CH_LC_G + 8'($urandom_range(0, 19)));
          end
          default: return;
        endcase
      end
    end
  endtask

  task random_phase(int idle, int stall, int count);
    int start;
    start = sent;
    send_idle = idle;
    stall_pct <= stall;
    while (sent - start < count) begin
      make_string();
      send_string();
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // octal overflow, flushes, open escapes at the end, bad escapes
    send_text("\\777");
    send_text("\\7q");
    send_text("\\4\\");
    send_text("\\x");
    send_text("\\qzz");
    send_text("\\xfG");
    send_text("\\12");
    send_text("\\xg");
    chars.delete();
    append_char(8'hFF);
    append_char(8'h01);
    send_string();
    drain();

    random_phase(0, 0, PHASE_CHARS);
    random_phase(75, 0, PHASE_CHARS);
    random_phase(0, 75, PHASE_CHARS);
    random_phase(20, 20, PHASE_CHARS);

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    random_phase(0, 0, PHASE_CHARS);

    repeat (20) @(posedge clk);
    if (board.pending() != 0) board.report("words still expected at the end");
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
